// ===== design/owm_pkg.sv =====
// Shared types and constants for the single-wire bus master.
package owm_pkg;

	localparam int CFG_WIDTH = 10;
	localparam int CFG_COUNT = 8;
	localparam int CFG_INDEX_WIDTH = 3;

	// register indexes
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESET_LOW    = 3'd0;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_PRESENCE_WAIT = 3'd1;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RESET_TAIL   = 3'd2;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_WRITE_ONE_LOW = 3'd3;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_WRITE_SLOT   = 3'd4;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_READ_LOW     = 3'd5;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_READ_TAIL    = 3'd6;
	localparam logic [CFG_INDEX_WIDTH-1:0] REG_RECOVERY     = 3'd7;

	localparam logic [CFG_WIDTH-1:0] CFG_RESET [CFG_COUNT] = '{
		10'd480, 10'd65, 10'd400, 10'd1, 10'd60, 10'd2, 10'd80, 10'd1
	};

	// command codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_RESET = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;
	localparam logic [1:0] CMD_READ  = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] tx_byte;
		logic       line_in;
	} owm_in_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       presence;
		logic       rejected;
	} owm_out_t;

endpackage

// ===== design/one_wire_bus_master.sv =====
// Single-wire open-drain bus master: reset/presence, byte write and byte read slots.
// The result word of an accepted tick word is registered in the output register.
// Throughput: one tick word per cycle; the phase, slot counter and shift register
// all update in the cycle the word is accepted, and the output register keeps taking
// words while the downstream side takes results.
// Reset: phase idle, counters and shift/result bytes zero, config registers at defaults.
module one_wire_bus_master #(
	parameter int COUNT_WIDTH = 10
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  owm_pkg::owm_in_t                      in_data,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output owm_pkg::owm_out_t                     out_data,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [owm_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
	input  logic [owm_pkg::CFG_WIDTH-1:0]         cfg_data
);
	import owm_pkg::*;

	localparam int CW = COUNT_WIDTH;
	localparam int LW = (CW > CFG_WIDTH) ? CW : CFG_WIDTH;
	localparam logic [LW-1:0] CNT_MAX = LW'((1 << CW) - 1);

	localparam logic [3:0] PH_IDLE     = 4'd0;
	localparam logic [3:0] PH_RST_LOW  = 4'd1;
	localparam logic [3:0] PH_RST_WAIT = 4'd2;
	localparam logic [3:0] PH_RST_TAIL = 4'd3;
	localparam logic [3:0] PH_W_LOW    = 4'd4;
	localparam logic [3:0] PH_W_REL    = 4'd5;
	localparam logic [3:0] PH_W_REC    = 4'd6;
	localparam logic [3:0] PH_R_LOW    = 4'd7;
	localparam logic [3:0] PH_R_TAIL   = 4'd8;

	logic [CFG_WIDTH-1:0] cfg_q [CFG_COUNT];
	logic [3:0]    phase_q, phase_n;
	logic [CW-1:0] tick_q, tick_n;
	logic [2:0]    bit_q, bit_n;
	logic [7:0]    shift_q, shift_n;
	logic          presence_q, presence_n;
	logic [7:0]    rx_q, rx_n;
	logic          out_valid_q;
	owm_out_t      out_q, res;
	logic          accept;

	// length capped at the counter maximum
	function automatic logic [CW-1:0] len_z(input logic [CFG_WIDTH-1:0] v);
		logic [LW-1:0] ve;
		ve = LW'(v);
		if (ve > CNT_MAX)
			return CNT_MAX[CW-1:0];
		return ve[CW-1:0];
	endfunction

	// as above, zero acts as one
	function automatic logic [CW-1:0] len1(input logic [CFG_WIDTH-1:0] v);
		logic [CW-1:0] z;
		z = len_z(v);
		return (z == '0) ? CW'(1) : z;
	endfunction

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

	always_comb begin
		logic [3:0]    ph;
		logic [CW-1:0] tc;
		logic [CW-1:0] lsel;
		logic [CW:0]   tc_inc;
		logic          fire;
		logic          bitv;
		logic          last_bit;

		ph         = phase_q;
		tc         = tick_q;
		bit_n      = bit_q;
		shift_n    = shift_q;
		presence_n = presence_q;
		rx_n       = rx_q;
		res        = '0;

		if (phase_q != PH_IDLE) begin
			res.rejected = (in_data.cmd != CMD_TICK);
		end else if (in_data.cmd != CMD_TICK) begin
			tc    = '0;
			bit_n = 3'd0;
			case (in_data.cmd)
				CMD_RESET: ph = PH_RST_LOW;
				CMD_WRITE: begin
					shift_n = in_data.tx_byte;
					ph      = PH_W_LOW;
				end
				default: begin
					shift_n = 8'd0;
					ph      = PH_R_LOW;
				end
			endcase
		end

		res.busy_res = (ph != PH_IDLE);
		bitv         = shift_n[bit_n];
		last_bit     = (bit_n == 3'd7);

		case (ph)
			PH_RST_LOW:  lsel = len1(cfg_q[REG_RESET_LOW]);
			PH_RST_WAIT: lsel = len1(cfg_q[REG_PRESENCE_WAIT]);
			PH_RST_TAIL: lsel = len_z(cfg_q[REG_RESET_TAIL]);
			PH_W_LOW:    lsel = bitv ? len1(cfg_q[REG_WRITE_ONE_LOW])
				: len1(cfg_q[REG_WRITE_SLOT]);
			PH_W_REL:    lsel = len1(cfg_q[REG_WRITE_SLOT]);
			PH_W_REC:    lsel = len1(cfg_q[REG_RECOVERY]);
			PH_R_LOW:    lsel = len1(cfg_q[REG_READ_LOW]);
			PH_R_TAIL:   lsel = len1(cfg_q[REG_READ_TAIL]);
			default:     lsel = '0;
		endcase

		tc_inc = {1'b0, tc} + 1'b1;
		fire   = (tc_inc >= {1'b0, lsel});
		phase_n = ph;
		tick_n  = tc;

		if (ph != PH_IDLE && ph <= PH_R_TAIL) begin
			tick_n = fire ? '0 : tc_inc[CW-1:0];
		end

		case (ph)
			PH_IDLE: ;
			PH_RST_LOW: begin
				res.drive_low = 1'b1;
				if (fire)
					phase_n = PH_RST_WAIT;
			end
			PH_RST_WAIT: begin
				if (fire) begin
					presence_n = !in_data.line_in;
					if (len_z(cfg_q[REG_RESET_TAIL]) == '0) begin
						phase_n      = PH_IDLE;
						res.done_res = 1'b1;
					end else begin
						phase_n = PH_RST_TAIL;
					end
				end
			end
			PH_RST_TAIL: begin
				if (fire) begin
					phase_n      = PH_IDLE;
					res.done_res = 1'b1;
				end
			end
			PH_W_LOW: begin
				res.drive_low = 1'b1;
				if (fire)
					phase_n = bitv ? PH_W_REL : PH_W_REC;
			end
			PH_W_REL, PH_W_REC: begin
				if (fire) begin
					if (last_bit) begin
						phase_n      = PH_IDLE;
						bit_n        = 3'd0;
						res.done_res = 1'b1;
					end else begin
						bit_n   = bit_n + 3'd1;
						phase_n = PH_W_LOW;
					end
				end
			end
			PH_R_LOW: begin
				res.drive_low = 1'b1;
				if (fire)
					phase_n = PH_R_TAIL;
			end
			PH_R_TAIL: begin
				// sample on the first released tick of the slot
				if (tc == '0)
					shift_n[bit_n] = shift_n[bit_n] | in_data.line_in;
				if (fire) begin
					if (last_bit) begin
						rx_n         = shift_n;
						phase_n      = PH_IDLE;
						bit_n        = 3'd0;
						res.done_res = 1'b1;
					end else begin
						bit_n   = bit_n + 3'd1;
						phase_n = PH_R_LOW;
					end
				end
			end
			default: begin
				phase_n = PH_IDLE;
				tick_n  = '0;
				bit_n   = 3'd0;
			end
		endcase

		res.rx_byte  = rx_n;
		res.presence = presence_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CFG_COUNT; i++)
				cfg_q[i] <= CFG_RESET[i];
		end else if (cfg_valid && cfg_ready) begin
			cfg_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			bit_q       <= 3'd0;
			shift_q     <= 8'd0;
			presence_q  <= 1'b0;
			rx_q        <= 8'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				phase_q    <= phase_n;
				tick_q     <= tick_n;
				bit_q      <= bit_n;
				shift_q    <= shift_n;
				presence_q <= presence_n;
				rx_q       <= rx_n;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			out_q <= res;
	end

endmodule
